[hw/rtl/wsrm_pkg.sv]
// wsrm_pkg: shared types and constants for the wildcard/star regex matcher.
// No dependencies; used by wsrm_ctrl, wsrm_datapath and the top level.

package wsrm_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 32;   // default pattern positions
    localparam int unsigned CFG_DATA_W      = 64;   // widest configuration register
    localparam int unsigned CFG_IDX_W       = 3;    // five registers
    localparam int unsigned LEN_CFG_W       = 6;    // stored pattern_length width
    localparam int unsigned NUM_WORDS       = 4;    // pattern words of eight bytes

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 3'd4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CLOSE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // take the input beat: restart set or byte advance
        logic close_step;  // apply one parallel closure step
        logic capture;     // register the full-match result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic changed;     // a closure step would change the position set
    } status_t;

endpackage

[hw/rtl/wsrm_ctrl.sv]
// wsrm_ctrl: sequencer for the regex matcher (accept, closure loop, result hand-off).
// Depends on wsrm_pkg.

module wsrm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  wsrm_pkg::status_t status,
    output wsrm_pkg::cmd_t    cmd
);

    wsrm_pkg::state_t state_reg;
    wsrm_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsrm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wsrm_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = wsrm_pkg::ST_CLOSE;
            end
            wsrm_pkg::ST_CLOSE:
            begin
                if (!status.changed && out_free)
                    state_next = wsrm_pkg::ST_IDLE;
            end
            default:
                state_next = wsrm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            wsrm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            wsrm_pkg::ST_CLOSE:
            begin
                // closure settled: hand result over once the output slot is free
                cmd.close_step = status.changed;
                cmd.capture    = !status.changed && out_free;
            end
            default:
            begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/wsrm_datapath.sv]
// wsrm_datapath: pattern registers, position vector, byte advance and closure step.
// Depends on wsrm_pkg.

module wsrm_datapath
#(
    parameter int unsigned MAX_PATTERN = wsrm_pkg::MAX_PATTERN_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [wsrm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wsrm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 mode,
    input  logic [7:0]                           text_byte,
    input  wsrm_pkg::cmd_t                       cmd,
    output wsrm_pkg::status_t                    status,
    output logic                                 full_match
);

    localparam int unsigned NPOS  = MAX_PATTERN + 1;
    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

    logic [wsrm_pkg::CFG_DATA_W-1:0] pat_word_reg [wsrm_pkg::NUM_WORDS];
    logic [wsrm_pkg::LEN_CFG_W-1:0]  len_cfg_reg;
    logic [NPOS-1:0]                 active_reg;
    logic [NPOS-1:0]                 active_next;
    logic                            match_reg;

    logic [wsrm_pkg::NUM_WORDS*wsrm_pkg::CFG_DATA_W-1:0] pat_flat;
    logic [LEN_W-1:0]  len_sat;
    logic [NPOS-1:0]   pos_mask;
    logic [NPOS-1:0]   advanced;
    logic [NPOS-1:0]   expanded;
    logic [MAX_PATTERN-1:0] is_star;
    logic [MAX_PATTERN-1:0] moves;

    assign pat_flat = {pat_word_reg[3], pat_word_reg[2], pat_word_reg[1], pat_word_reg[0]};

    // lengths above MAX_PATTERN saturate
    assign len_sat = (len_cfg_reg > wsrm_pkg::LEN_CFG_W'(MAX_PATTERN))
                   ? LEN_W'(MAX_PATTERN) : LEN_W'(len_cfg_reg);

    genvar k;
    generate
        for (k = 0; k < NPOS; k++)
        begin : g_mask
            assign pos_mask[k] = (LEN_W'(k) <= len_sat);
        end

        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_pos
            logic [7:0] pc;
            logic       in_use;
            assign pc         = pat_flat[8*k +: 8];
            assign in_use     = (LEN_W'(k) < len_sat);
            assign is_star[k] = in_use && (pc == wsrm_pkg::STAR_CHAR);
            // a '*' never consumes a byte
            assign moves[k]   = in_use && (pc != wsrm_pkg::STAR_CHAR)
                              && ((pc == text_byte) || (pc == wsrm_pkg::DOT_CHAR));
        end

        assign advanced[0] = 1'b0;
        for (k = 1; k < NPOS; k++)
        begin : g_adv
            assign advanced[k] = active_reg[k-1] && pos_mask[k-1] && moves[k-1];
        end

        // one parallel empty-move step: star i links i-1 <-> i and i -> i+1
        for (k = 0; k < NPOS; k++)
        begin : g_exp
            logic from_left;
            logic from_right;
            if (k == 0)
            begin : g_first
                assign from_left = 1'b0;
            end
            else if (k < MAX_PATTERN)
            begin : g_mid
                assign from_left = (is_star[k-1] && active_reg[k-1])
                                 || (is_star[k] && active_reg[k-1]);
            end
            else
            begin : g_last
                assign from_left = is_star[k-1] && active_reg[k-1];
            end
            if (k + 1 < MAX_PATTERN && k + 1 > 0)
            begin : g_back
                assign from_right = is_star[k+1] && active_reg[k+1];
            end
            else
            begin : g_noback
                assign from_right = 1'b0;
            end
            assign expanded[k] = (active_reg[k] || from_left || from_right) && pos_mask[k];
        end
    endgenerate

    always_comb
    begin
        active_next = active_reg;
        if (cmd.load)
        begin
            if (mode)
                active_next = NPOS'(1);
            else
                active_next = advanced;
        end
        else if (cmd.close_step)
        begin
            active_next = expanded;
        end
    end

    assign status.changed = (expanded != active_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < wsrm_pkg::NUM_WORDS; w++)
                pat_word_reg[w] <= '0;
            len_cfg_reg <= '0;
            active_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wsrm_pkg::CFG_PAT_0_7:   pat_word_reg[0] <= cfg_data;
                    wsrm_pkg::CFG_PAT_8_15:  pat_word_reg[1] <= cfg_data;
                    wsrm_pkg::CFG_PAT_16_23: pat_word_reg[2] <= cfg_data;
                    wsrm_pkg::CFG_PAT_24_31: pat_word_reg[3] <= cfg_data;
                    wsrm_pkg::CFG_LENGTH:
                        len_cfg_reg <= cfg_data[wsrm_pkg::LEN_CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            match_reg <= active_reg[len_sat];
    end

    assign full_match = match_reg;

endmodule

[hw/rtl/wildcard_star_regex_matcher.sv]
// wildcard_star_regex_matcher: top level of the literal / '.' / '*' regex matcher.
// Depends on wsrm_pkg, wsrm_ctrl and wsrm_datapath.
//
// Usage:
//   Input stream (s_axis_*): one beat per text item. tuser = mode (1 restarts at
//   the start closure, 0 consumes tdata as a text byte; tdata ignored on restart).
//   Output stream (m_axis_*): one beat per input beat, tdata bit 0 = full_match,
//   1 when the text since the last restart matches the whole pattern.
//   Config port: cfg_we/cfg_index/cfg_data; index 0..3 load pattern bytes 0-7,
//   8-15, 16-23, 24-31 (lowest byte first), index 4 loads pattern_length.
//   Write only while no beat is in flight.
// Timing:
//   One beat in work at a time. After acceptance the position vector is loaded in
//   the same edge, then the empty-move closure is iterated, one parallel step per
//   cycle, until nothing changes. The next beat is accepted in the cycle after the
//   result is registered.
// Reset: pattern and length clear, no position active (full_match 0 before any
//   restart), output empty.
// Stall: a pending result sits in the output register while the next beat is
//   accepted; a second result waits in the closure loop until the slot frees.

module wildcard_star_regex_matcher
#(
    parameter int unsigned MAX_PATTERN = wsrm_pkg::MAX_PATTERN_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wsrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wsrm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [7:0] text_byte
    input  logic                               s_axis_tuser,  // [0] mode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata   // [0] full_match, [7:1] zero
);

    wsrm_pkg::cmd_t    cmd;
    wsrm_pkg::status_t status;
    logic              full_match;

    wsrm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    wsrm_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (s_axis_tuser),
        .text_byte  (s_axis_tdata),
        .cmd        (cmd),
        .status     (status),
        .full_match (full_match)
    );

    assign m_axis_tdata = {7'd0, full_match};

    // one beat in work: no acceptance right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a beat is in work");

    // a captured result is presented next cycle
    a_capture_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> m_axis_tvalid)
        else $error("captured result not presented");

    // capture only once the closure has settled, never together with a load
    a_capture_settled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!status.changed && !cmd.load && !cmd.close_step))
        else $error("result captured before closure settled");

    // output slot never overwritten while a result is stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !cmd.capture)
        else $error("pending result overwritten");

endmodule

[dv/tb_wildcard_star_regex_matcher.sv]
// tb_wildcard_star_regex_matcher: self-checking testbench for the literal / '.' / '*'
// regex matcher. Predicts full_match per text beat and checks the result stream.
// Depends on wsrm_pkg and the wildcard_star_regex_matcher top level.

module tb_wildcard_star_regex_matcher;

    timeunit 1ns;
    timeprecision 1ps;

    // input beat kinds carried on s_axis_tuser
    localparam bit MODE_TEXT    = 1'b0;
    localparam bit MODE_RESTART = 1'b1;

    localparam int unsigned RANDOM_BEATS = 1930;
    localparam int unsigned HOLD_CYCLES  = 300;      // long receiver back-pressure
    localparam int unsigned TAIL_CYCLES  = 48;       // > worst closure latency
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        bit         mode;
        logic [7:0] text;
    } text_beat_t;

    // ------------------------------------------------------------------
    // Position-set predictor plus queue of expected full_match values.
    // One bit per pattern position, bit len is the accepting position.
    // ------------------------------------------------------------------
    class match_tracker;
        logic [63:0] pat_word [4];
        logic [5:0]  len_reg;
        logic [32:0] active;
        bit          expected_full_match [$];
        int unsigned mismatches;

        function new();
            for (int w = 0; w < 4; w++)
                pat_word[w] = '0;
            len_reg    = '0;
            active     = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [wsrm_pkg::CFG_IDX_W-1:0] idx,
                                logic [wsrm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                wsrm_pkg::CFG_PAT_0_7:   pat_word[0] = data;
                wsrm_pkg::CFG_PAT_8_15:  pat_word[1] = data;
                wsrm_pkg::CFG_PAT_16_23: pat_word[2] = data;
                wsrm_pkg::CFG_PAT_24_31: pat_word[3] = data;
                wsrm_pkg::CFG_LENGTH:    len_reg     = data[wsrm_pkg::LEN_CFG_W-1:0];
                default:       ;
            endcase
        endfunction

        // stored length saturates at the number of positions
        function int unsigned used_len();
            return (len_reg > wsrm_pkg::MAX_PATTERN_DEF) ? wsrm_pkg::MAX_PATTERN_DEF
                                                         : int'(len_reg);
        endfunction

        function logic [7:0] pat_at(int unsigned p);
            return pat_word[p / 8][(p % 8) * 8 +: 8];
        endfunction

        // positions 0..len inclusive
        function logic [32:0] span(int unsigned len);
            return {33{1'b1}} >> (wsrm_pkg::MAX_PATTERN_DEF - len);
        endfunction

        // empty-move closure: a star at i links i-1 -> i, i -> i-1, i -> i+1;
        // a star at position zero only has its forward move
        function logic [32:0] close_positions(logic [32:0] set, int unsigned len);
            logic [32:0] prev;
            set &= span(len);
            do
            begin
                prev = set;
                for (int unsigned i = 0; i < len; i++)
                begin
                    if (pat_at(i) == wsrm_pkg::STAR_CHAR)
                    begin
                        if (i > 0 && set[i-1])
                            set[i] = 1'b1;
                        if (set[i])
                        begin
                            if (i > 0)
                                set[i-1] = 1'b1;
                            set[i+1] = 1'b1;
                        end
                    end
                end
            end
            while (set != prev);
            return set;
        endfunction

        // advance the position set by one accepted beat, queue the verdict
        function void take_beat(bit mode, logic [7:0] text);
            int unsigned len;
            logic [32:0] cur;
            logic [32:0] nxt;
            logic [7:0]  pc;
            len = used_len();
            if (mode == MODE_RESTART)
                active = close_positions(33'd1, len);
            else
            begin
                // bits above the accepting position drop out here
                cur = active & span(len);
                nxt = '0;
                for (int unsigned j = 0; j < len; j++)
                begin
                    pc = pat_at(j);
                    // a star position never consumes, even a literal '*'
                    if (cur[j] && pc != wsrm_pkg::STAR_CHAR
                        && (pc == text || pc == wsrm_pkg::DOT_CHAR))
                        nxt[j+1] = 1'b1;
                end
                active = close_positions(nxt, len);
            end
            expected_full_match.push_back(active[len]);
        endfunction

        function void compare_match(logic [7:0] tdata);
            bit want;
            if (expected_full_match.size() == 0)
            begin
                $error("result beat with nothing pending: full_match=%0d", tdata[0]);
                mismatches++;
                return;
            end
            want = expected_full_match.pop_front();
            if (tdata[0] !== want)
            begin
                $error("full_match: expected %0d, got %0d", want, tdata[0]);
                mismatches++;
            end
            if (tdata[7:1] !== 7'd0)
            begin
                $error("tdata pad: expected 0, got 0x%02h", tdata[7:1]);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_full_match.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [wsrm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wsrm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;   // [7:0] text_byte
    logic                            s_axis_tuser;   // [0] mode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [7:0]                      m_axis_tdata;   // [0] full_match, [7:1] zero

    wildcard_star_regex_matcher u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    match_tracker tracker;

    bit          quiet;          // phase runs with no idling on either side
    bit          hold_request;   // ask the receiver for one long stall
    int unsigned cycle_count;

    logic [7:0]  pat_buf [32];   // current pattern, for building matching text
    int unsigned pat_len;        // effective (saturated) length

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("wildcard_star_regex_matcher test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Every task that returns leaves the caller at a falling
    // edge, with no assignment to tvalid made yet in that step unless the
    // gap branch made it in an earlier step.
    // ------------------------------------------------------------------

    // called at a falling edge: offer one beat, wait for the handshake,
    // then sit out the drawn gap
    task automatic send_beat(bit mode, logic [7:0] text);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= text;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        tracker.take_beat(mode, text);
        gap = quiet ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop offering and wait until every result is back; block is idle then
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [wsrm_pkg::CFG_IDX_W-1:0] idx,
                             logic [wsrm_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly small literals, dots and stars; a few arbitrary bytes so that
    // high text bits also have to match
    function automatic logic [7:0] random_pattern_byte();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 8)
            return 8'h61 + 8'($urandom_range(0, 2));
        else if (roll < 12)
            return wsrm_pkg::DOT_CHAR;
        else if (roll < 17)
            return wsrm_pkg::STAR_CHAR;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // new random pattern; length mostly short, sometimes up to full, rarely over range
    task automatic load_random_pattern();
        logic [63:0] word [4];
        int unsigned roll;
        int unsigned len_value;
        roll = $urandom_range(0, 19);
        if (roll < 13)
            len_value = $urandom_range(0, 8);
        else if (roll < 18)
            len_value = $urandom_range(9, 32);
        else
            len_value = $urandom_range(33, 63);
        for (int p = 0; p < 32; p++)
            pat_buf[p] = random_pattern_byte();
        for (int w = 0; w < 4; w++)
            for (int k = 0; k < 8; k++)
                word[w][k*8 +: 8] = pat_buf[w*8 + k];
        write_reg(wsrm_pkg::CFG_PAT_0_7,   word[0]);
        write_reg(wsrm_pkg::CFG_PAT_8_15,  word[1]);
        write_reg(wsrm_pkg::CFG_PAT_16_23, word[2]);
        write_reg(wsrm_pkg::CFG_PAT_24_31, word[3]);
        write_reg(wsrm_pkg::CFG_LENGTH,    64'(len_value));
        pat_len = (len_value > wsrm_pkg::MAX_PATTERN_DEF) ? wsrm_pkg::MAX_PATTERN_DEF
                                                          : len_value;
    endtask

    // Text that walks the pattern: x* repeats x 0..3 times, '.' takes any
    // byte, a stray star (none before it) is skipped. typo_pct corrupts
    // bytes to get near misses.
    task automatic build_text(ref text_beat_t seq[$], input int unsigned typo_pct);
        int unsigned j;
        int unsigned reps;
        bit          starred;
        logic [7:0]  c;
        text_beat_t  b;
        j = 0;
        while (j < pat_len)
        begin
            c = pat_buf[j];
            if (c == wsrm_pkg::STAR_CHAR)
                j++;
            else
            begin
                starred = (j + 1 < pat_len) && (pat_buf[j+1] == wsrm_pkg::STAR_CHAR);
                reps = starred ? $urandom_range(0, 3) : 1;
                repeat (reps)
                begin
                    b.mode = MODE_TEXT;
                    b.text = (c == wsrm_pkg::DOT_CHAR) ? 8'($urandom_range(0, 255)) : c;
                    if ($urandom_range(0, 99) < typo_pct)
                        b.text = 8'($urandom_range(0, 255));
                    seq.push_back(b);
                end
                j += starred ? 2 : 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: per-result stall 0..17, one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 17);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            tracker.compare_match(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        text_beat_t  seq [$];
        text_beat_t  b;
        int unsigned sent;
        int unsigned phase_beats;
        int unsigned phase_sent;
        int unsigned phase_no;
        int unsigned kind;
        int unsigned n;
        bit          first_seq;

        tracker       = new();
        cycle_count   = 0;
        quiet         = 1'b0;
        hold_request  = 1'b0;
        pat_len       = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_TEXT;
        for (int p = 0; p < 32; p++)
            pat_buf[p] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed ---------------------------------------------------
        // nothing active before the first restart
        send_beat(MODE_TEXT, 8'h61);
        send_beat(MODE_TEXT, 8'hFF);
        // empty pattern: restart matches, any byte after it does not
        send_beat(MODE_RESTART, 8'h00);
        send_beat(MODE_TEXT, 8'h00);
        drain();

        // "*ab*": leading star only moves forward; literal '*' text never
        // gets through a star position
        write_reg(wsrm_pkg::CFG_PAT_0_7, 64'h0000_0000_2A62_612A);
        write_reg(wsrm_pkg::CFG_LENGTH, 64'd4);
        send_beat(MODE_RESTART, 8'hFF);
        send_beat(MODE_TEXT, 8'h61);
        send_beat(MODE_TEXT, 8'h62);
        send_beat(MODE_TEXT, 8'h62);
        send_beat(MODE_TEXT, wsrm_pkg::STAR_CHAR);
        send_beat(MODE_RESTART, 8'h5A);
        send_beat(MODE_TEXT, 8'h61);
        drain();

        // "a*" x16 over all 32 positions; length 63 saturates to 32 and the
        // restart closure runs the whole chain
        write_reg(wsrm_pkg::CFG_PAT_0_7,   64'h2A61_2A61_2A61_2A61);
        write_reg(wsrm_pkg::CFG_PAT_8_15,  64'h2A61_2A61_2A61_2A61);
        write_reg(wsrm_pkg::CFG_PAT_16_23, 64'h2A61_2A61_2A61_2A61);
        write_reg(wsrm_pkg::CFG_PAT_24_31, 64'h2A61_2A61_2A61_2A61);
        write_reg(wsrm_pkg::CFG_LENGTH, 64'd63);
        send_beat(MODE_RESTART, 8'h00);
        send_beat(MODE_TEXT, 8'h61);
        send_beat(MODE_TEXT, 8'h62);
        send_beat(MODE_RESTART, 8'hA5);
        drain();

        // shrink and regrow the pattern mid-text: upper bits must be dropped
        write_reg(wsrm_pkg::CFG_LENGTH, 64'd1);
        send_beat(MODE_TEXT, 8'h61);
        drain();
        write_reg(wsrm_pkg::CFG_LENGTH, 64'd32);
        send_beat(MODE_TEXT, 8'h61);
        drain();
        write_reg(wsrm_pkg::CFG_LENGTH, 64'd0);
        send_beat(MODE_TEXT, 8'h61);

        // --- random phases ---------------------------------------------
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_BEATS)
        begin
            drain();
            load_random_pattern();
            phase_beats = $urandom_range(30, 110);
            phase_sent  = 0;
            quiet       = ($urandom_range(0, 3) == 0);
            if (phase_no == 2)
                hold_request = 1'b1;   // sender keeps offering meanwhile
            first_seq = 1'b1;
            while (phase_sent < phase_beats)
            begin
                seq.delete();
                kind = $urandom_range(0, 9);
                if (kind == 9)
                begin
                    // noise: arbitrary bytes, stray restarts
                    n = $urandom_range(1, 8);
                    repeat (n)
                    begin
                        b.mode = ($urandom_range(0, 5) == 0) ? MODE_RESTART : MODE_TEXT;
                        b.text = 8'($urandom_range(0, 255));
                        seq.push_back(b);
                    end
                end
                else
                begin
                    // keep the old positions now and then across a pattern change
                    if (!(first_seq && $urandom_range(0, 3) == 0))
                    begin
                        b.mode = MODE_RESTART;
                        b.text = 8'($urandom_range(0, 255));
                        seq.push_back(b);
                    end
                    build_text(seq, (kind < 7) ? 0 : 20);
                    if ($urandom_range(0, 4) == 0)
                    begin
                        b.mode = MODE_TEXT;
                        b.text = ($urandom_range(0, 1) == 0) ? pat_buf[$urandom_range(0, 31)]
                                                             : 8'($urandom_range(0, 255));
                        seq.push_back(b);
                    end
                end
                foreach (seq[i])
                    send_beat(seq[i].mode, seq[i].text);
                phase_sent += seq.size();
                first_seq = 1'b0;
                // occasional full pause mid-phase
                if ($urandom_range(0, 15) == 0)
                    drain();
            end
            sent += phase_sent;
            phase_no++;
        end

        // --- wind down --------------------------------------------------
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("wildcard_star_regex_matcher test passed");
        else
            $display("wildcard_star_regex_matcher test failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/wsrm_pkg.sv
hw/rtl/wsrm_ctrl.sv
hw/rtl/wsrm_datapath.sv
hw/rtl/wildcard_star_regex_matcher.sv
dv/tb_wildcard_star_regex_matcher.sv
